>>> rtl/clock_page_replacement_defines.svh
// Assertion macros for the clock page replacement block.
`ifndef CLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define CPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CPR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CPR_ASSERT(lbl, prop, msg)
`define CPR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/cpr_pkg.sv
package cpr_pkg;

    localparam int MAX_FRAMES  = 8;
    localparam int FRAME_IDX_W = $clog2(MAX_FRAMES);
    localparam int FC_W        = 4;
    localparam int PAGE_W      = 16;
    localparam int CNT_W       = 16;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [FC_W-1:0]  FC_RESET  = 4'd4;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    typedef logic [OP_W-1:0] opcode_t;

    localparam opcode_t OP_ACCESS  = 2'd0;
    localparam opcode_t OP_PRELOAD = 2'd1;
    localparam opcode_t OP_RESTART = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_FRAME_COUNT  = 1'd0;
    localparam cfg_idx_t REG_START_AT_TOP = 1'd1;

    // controller -> datapath, at most one set per cycle
    typedef struct packed {
        logic capture;
        logic exec;
        logic skip;
        logic load;
    } cpr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic access;
        logic hit;
        logic use_at_hand;
    } cpr_status_t;

endpackage

>>> rtl/clock_page_replacement.sv
// Clock (second chance) page replacement over up to eight frames. One result per input
// item. A hit, preload, restart or unused opcode is captured at transfer, then gets a
// parallel tag compare over the frames in use and the update, then its result; a miss
// adds the one-frame-per-cycle hand sweep, which clears each set use bit the hand passes,
// and then loads the frame at the hand (effective frame count clamped to 1..8).
// A new item is taken in the cycle its predecessor's result transfers.
// The user must write configuration only while idle; the block itself does not enforce it.
module clock_page_replacement (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  cpr_pkg::cfg_idx_t                  cfg_index,
    input  logic [cpr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  cpr_pkg::opcode_t                   opcode,
    input  logic [cpr_pkg::PAGE_W-1:0]         page,
    input  logic [cpr_pkg::FRAME_IDX_W-1:0]    frame_slot,
    input  logic                               use_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               hit,
    output logic [cpr_pkg::FRAME_IDX_W-1:0]    frame_touched,
    output logic                               evicted_valid,
    output logic [cpr_pkg::PAGE_W-1:0]         evicted_page,
    output logic [cpr_pkg::CNT_W-1:0]          fault_total,
    output logic [cpr_pkg::CNT_W-1:0]          replace_total
);

    cpr_pkg::cpr_cmd_t    cmd;
    cpr_pkg::cpr_status_t status;

    cpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cpr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .page          (page),
        .frame_slot    (frame_slot),
        .use_value     (use_value),
        .cmd           (cmd),
        .status        (status),
        .hit           (hit),
        .frame_touched (frame_touched),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total),
        .replace_total (replace_total)
    );

endmodule

>>> rtl/cpr_datapath.sv
module cpr_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  cpr_pkg::cfg_idx_t                  cfg_index,
    input  logic [cpr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  cpr_pkg::opcode_t                   opcode,
    input  logic [cpr_pkg::PAGE_W-1:0]         page,
    input  logic [cpr_pkg::FRAME_IDX_W-1:0]    frame_slot,
    input  logic                               use_value,
    input  cpr_pkg::cpr_cmd_t                  cmd,
    output cpr_pkg::cpr_status_t               status,
    output logic                               hit,
    output logic [cpr_pkg::FRAME_IDX_W-1:0]    frame_touched,
    output logic                               evicted_valid,
    output logic [cpr_pkg::PAGE_W-1:0]         evicted_page,
    output logic [cpr_pkg::CNT_W-1:0]          fault_total,
    output logic [cpr_pkg::CNT_W-1:0]          replace_total
);

    localparam int NF = cpr_pkg::MAX_FRAMES;
    localparam int IW = cpr_pkg::FRAME_IDX_W;
    localparam int FW = cpr_pkg::FC_W;
    localparam int PW = cpr_pkg::PAGE_W;
    localparam int CW = cpr_pkg::CNT_W;

    logic [FW-1:0]      frame_count_reg;
    logic               start_at_top_reg;

    cpr_pkg::opcode_t   op_reg;
    logic [PW-1:0]      page_reg;
    logic [IW-1:0]      slot_reg;
    logic               use_in_reg;

    logic [PW-1:0]      frame_page_reg [NF];
    logic [PW-1:0]      frame_page_next [NF];
    logic [NF-1:0]      frame_valid_reg, frame_valid_next;
    logic [NF-1:0]      use_flag_reg, use_flag_next;
    logic [IW-1:0]      hand_reg, hand_next;
    logic [CW-1:0]      fault_reg, fault_next;
    logic [CW-1:0]      replace_reg, replace_next;

    logic               hit_reg, hit_next;
    logic [IW-1:0]      touched_reg, touched_next;
    logic               ev_valid_reg, ev_valid_next;
    logic [PW-1:0]      ev_page_reg, ev_page_next;

    logic [FW-1:0]      fc_eff;
    logic [IW-1:0]      hand_norm;
    logic [IW-1:0]      hand_inc;
    logic [IW-1:0]      restart_hand;
    logic               hit_any;
    logic [IW-1:0]      hit_idx;

    always_comb
    begin
        if (frame_count_reg == '0)
            fc_eff = FW'(1);
        else if (frame_count_reg > FW'(NF))
            fc_eff = FW'(NF);
        else
            fc_eff = frame_count_reg;
    end

    assign hand_norm    = ({1'b0, hand_reg} >= fc_eff) ? '0 : hand_reg;
    assign hand_inc     = ({1'b0, hand_reg} + FW'(1) == fc_eff) ? '0 : hand_reg + IW'(1);
    assign restart_hand = start_at_top_reg ? IW'(fc_eff - FW'(1)) : '0;

    // lowest valid matching frame below the frame count
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int j = NF - 1; j >= 0; j--)
        begin
            if ((FW'(j) < fc_eff) && frame_valid_reg[j] && (frame_page_reg[j] == page_reg))
            begin
                hit_any = 1'b1;
                hit_idx = IW'(j);
            end
        end
    end

    assign status.access      = (op_reg == cpr_pkg::OP_ACCESS);
    assign status.hit         = hit_any;
    assign status.use_at_hand = use_flag_reg[hand_reg];

    always_comb
    begin
        frame_page_next  = frame_page_reg;
        frame_valid_next = frame_valid_reg;
        use_flag_next    = use_flag_reg;
        hand_next        = hand_reg;
        fault_next       = fault_reg;
        replace_next     = replace_reg;
        hit_next         = hit_reg;
        touched_next     = touched_reg;
        ev_valid_next    = ev_valid_reg;
        ev_page_next     = ev_page_reg;

        priority if (cmd.exec)
        begin
            hit_next      = 1'b0;
            touched_next  = '0;
            ev_valid_next = 1'b0;
            ev_page_next  = '0;
            unique case (op_reg)
                cpr_pkg::OP_ACCESS:
                begin
                    hand_next = hand_norm;
                    if (hit_any)
                    begin
                        use_flag_next[hit_idx] = 1'b1;
                        hit_next               = 1'b1;
                        touched_next           = hit_idx;
                    end
                end
                cpr_pkg::OP_PRELOAD:
                begin
                    frame_page_next[slot_reg]  = page_reg;
                    frame_valid_next[slot_reg] = 1'b1;
                    use_flag_next[slot_reg]    = use_in_reg;
                    touched_next               = slot_reg;
                end
                cpr_pkg::OP_RESTART:
                begin
                    frame_valid_next = '0;
                    use_flag_next    = '0;
                    fault_next       = '0;
                    replace_next     = '0;
                    hand_next        = restart_hand;
                    touched_next     = restart_hand;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.skip)
        begin
            use_flag_next[hand_reg] = 1'b0;
            hand_next               = hand_inc;
        end
        else if (cmd.load)
        begin
            if (fault_reg != cpr_pkg::CNT_MAX)
                fault_next = fault_reg + CW'(1);
            if (frame_valid_reg[hand_reg])
            begin
                ev_valid_next = 1'b1;
                ev_page_next  = frame_page_reg[hand_reg];
                if (replace_reg != cpr_pkg::CNT_MAX)
                    replace_next = replace_reg + CW'(1);
            end
            frame_page_next[hand_reg]  = page_reg;
            frame_valid_next[hand_reg] = 1'b1;
            use_flag_next[hand_reg]    = 1'b1;
            touched_next               = hand_reg;
            hand_next                  = hand_inc;
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg  <= cpr_pkg::FC_RESET;
            start_at_top_reg <= 1'b0;
            frame_valid_reg  <= '0;
            use_flag_reg     <= '0;
            hand_reg         <= '0;
            fault_reg        <= '0;
            replace_reg      <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                if (cfg_index == cpr_pkg::REG_FRAME_COUNT)
                    frame_count_reg <= cfg_data[FW-1:0];
                else if (cfg_index == cpr_pkg::REG_START_AT_TOP)
                    start_at_top_reg <= cfg_data[0];
            end
            frame_valid_reg <= frame_valid_next;
            use_flag_reg    <= use_flag_next;
            hand_reg        <= hand_next;
            fault_reg       <= fault_next;
            replace_reg     <= replace_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= opcode;
            page_reg   <= page;
            slot_reg   <= frame_slot;
            use_in_reg <= use_value;
        end
        frame_page_reg <= frame_page_next;
        hit_reg        <= hit_next;
        touched_reg    <= touched_next;
        ev_valid_reg   <= ev_valid_next;
        ev_page_reg    <= ev_page_next;
    end

    assign hit           = hit_reg;
    assign frame_touched = touched_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_total   = fault_reg;
    assign replace_total = replace_reg;

endmodule

>>> rtl/cpr_ctrl.sv
`include "clock_page_replacement_defines.svh"

module cpr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  cpr_pkg::cpr_status_t  status,
    output cpr_pkg::cpr_cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_RESP) && out_ready);
    assign out_valid = (state_reg == ST_RESP);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.access && !status.hit)
                    state_next = ST_SWEEP;
                else
                    state_next = ST_RESP;
            end
            ST_SWEEP:
            begin
                if (status.use_at_hand)
                    cmd.skip = 1'b1;
                else
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_EXEC;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `CPR_ASSERT(a_sweep_only_on_access,
                (state_reg == ST_SWEEP) |-> status.access,
                "sweep on non-access item")
    `CPR_ASSERT(a_load_ends_sweep,
                ((state_reg == ST_SWEEP) && !status.use_at_hand) |=> (state_reg == ST_RESP),
                "load did not finish item")
    `CPR_ASSERT(a_transfer_starts_exec,
                (in_valid && in_ready) |=> (state_reg == ST_EXEC),
                "accepted item not executed")

endmodule
